// ===== sv/gkc_pkg.sv =====
// gkc_pkg: shared constants, register codes and helpers for the grid kernel
// convolution block. No dependencies; imported by the top level and the testbench.
package gkc_pkg;

  localparam int MaxSide    = 32;
  localparam int PosW       = $clog2(MaxSide);
  localparam int StoreDepth = MaxSide * MaxSide;
  localparam int AddrW      = $clog2(StoreDepth);

  localparam int SideW   = 6;
  localparam int SpaceW  = 24;
  localparam int SampleW = 32;
  localparam int PotW    = 48;

  // Kernel arithmetic widths
  localparam int HsqW  = 2 * SpaceW;   // h^2, Q16.32
  localparam int D2W   = 2 * PosW + 1; // di^2 + dj^2
  localparam int ProdW = 42;           // h^2*d2 clamped to 2^41
  localparam int T16W  = 26;           // t rounded to Q.16
  localparam int SqW   = 2 * T16W;
  localparam int RemW  = SqW + 1;
  localparam int KW    = 17;           // kernel, Q1.16
  localparam int TermW = SampleW + 2;

  // Register indexes on the configuration port
  localparam logic [1:0] RegCols    = 2'd0;
  localparam logic [1:0] RegRows    = 2'd1;
  localparam logic [1:0] RegSpacing = 2'd2;

  localparam logic [SideW-1:0] SideMax = SideW'(MaxSide);

  // Clamp a programmed size into 1..MaxSide
  function automatic logic [SideW-1:0] side_eff(input logic [SideW-1:0] v);
    logic [SideW-1:0] r;
    if (v == '0) begin
      r = SideW'(1);
    end else if (v > SideMax) begin
      r = SideMax;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== sv/gkc_ram.sv =====
// gkc_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module gkc_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/grid_kernel_convolution_2d.sv =====
// Timing: a load request never raises busy; a read request holds busy while
// all grid points pass the pipeline and ends with a one-cycle valid_o strobe.
// Throughput: one grid point per cycle through the kernel/MAC pipeline, set by
// the single read port of the sample RAM. Results cannot be stalled.
// Reset: registers return to 32x32 grid, h = 1.0, positions zero; sample RAM
// contents are undefined until loaded. Depends on gkc_pkg and gkc_ram.
module grid_kernel_convolution_2d (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           action_i,
  input  logic signed [gkc_pkg::SampleW-1:0] sample_i,
  // result channel
  output logic                           valid_o,
  output logic signed [gkc_pkg::PotW-1:0] potential_o,
  output logic                           last_point_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import gkc_pkg::*;

  localparam int DivSteps = KW;
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRun   = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [HsqW+D2W-1:0] ProdLimit = (HsqW+D2W)'(1) << 41;

  // Configuration registers
  logic [SideW-1:0]  cols_q, rows_q;
  logic [SpaceW-1:0] spacing_q;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      RegCols:    prdata = {26'd0, cols_q};
      RegRows:    prdata = {26'd0, rows_q};
      RegSpacing: prdata = {8'd0, spacing_q};
      default:    prdata = '0;
    endcase
  end

  // Effective sizes
  logic [SideW-1:0] cols_eff, rows_eff, cols_m1, rows_m1;
  logic [PosW-1:0]  col_max, row_max;
  logic [11:0]      n_pts, n_last;

  assign cols_eff = side_eff(cols_q);
  assign rows_eff = side_eff(rows_q);
  assign cols_m1  = cols_eff - SideW'(1);
  assign rows_m1  = rows_eff - SideW'(1);
  assign col_max  = cols_m1[PosW-1:0];
  assign row_max  = rows_m1[PosW-1:0];
  assign n_pts    = {6'd0, cols_eff} * {6'd0, rows_eff};
  assign n_last   = n_pts - 12'd1;

  // h^2, refreshed every cycle from the spacing register
  logic [HsqW-1:0] hsq_q;
  always_ff @(posedge clk_i) begin
    hsq_q <= {SpaceW'(0), spacing_q} * {SpaceW'(0), spacing_q};
  end

  // Control state
  logic [1:0]       state_q;
  logic [AddrW-1:0] load_addr_q;
  logic [PosW-1:0]  rd_col_q, rd_row_q;
  logic [PosW-1:0]  wc_q, wr_q;
  logic [AddrW-1:0] waddr_q;
  logic             accept, load_req, read_req, issue, issue_last;
  logic             h_v, h_last;

  assign busy       = (state_q != StIdle);
  assign accept     = start && !busy;
  assign load_req   = accept && !action_i;
  assign read_req   = accept && action_i;
  assign issue      = (state_q == StRun);
  assign issue_last = (wc_q == col_max) && (wr_q == row_max);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q      <= SideW'(32);
      rows_q      <= SideW'(32);
      spacing_q   <= SpaceW'(65536);
      state_q     <= StIdle;
      load_addr_q <= '0;
      rd_col_q    <= '0;
      rd_row_q    <= '0;
      wc_q        <= '0;
      wr_q        <= '0;
      waddr_q     <= '0;
    end else begin
      // register writes; a size change restarts both positions
      if (cfg_wr) begin
        unique case (cfg_idx)
          RegCols: begin
            cols_q      <= pwdata[SideW-1:0];
            load_addr_q <= '0;
            rd_col_q    <= '0;
            rd_row_q    <= '0;
          end
          RegRows: begin
            rows_q      <= pwdata[SideW-1:0];
            load_addr_q <= '0;
            rd_col_q    <= '0;
            rd_row_q    <= '0;
          end
          RegSpacing: spacing_q <= pwdata[SpaceW-1:0];
          default: ;
        endcase
      end
      if (load_req) begin
        load_addr_q <= (load_addr_q == n_last[AddrW-1:0]) ? '0 : load_addr_q + AddrW'(1);
      end
      unique case (state_q)
        StIdle: begin
          if (read_req) begin
            state_q <= StRun;
            wc_q    <= '0;
            wr_q    <= '0;
            waddr_q <= '0;
          end
        end
        StRun: begin
          waddr_q <= waddr_q + AddrW'(1);
          if (wc_q == col_max) begin
            wc_q <= '0;
            wr_q <= wr_q + PosW'(1);
          end else begin
            wc_q <= wc_q + PosW'(1);
          end
          if (issue_last) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (h_v && h_last) begin
            state_q <= StIdle;
            if (rd_col_q == col_max) begin
              rd_col_q <= '0;
              rd_row_q <= (rd_row_q == row_max) ? '0 : rd_row_q + PosW'(1);
            end else begin
              rd_col_q <= rd_col_q + PosW'(1);
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Stage A: squared distance to the point being read
  logic [PosW-1:0]   di, dj;
  logic [2*PosW-1:0] di2, dj2;
  logic              a_v, a_last;
  logic [AddrW-1:0]  a_addr;
  logic [D2W-1:0]    a_d2;

  assign di  = (wc_q > rd_col_q) ? wc_q - rd_col_q : rd_col_q - wc_q;
  assign dj  = (wr_q > rd_row_q) ? wr_q - rd_row_q : rd_row_q - wr_q;
  assign di2 = {PosW'(0), di} * {PosW'(0), di};
  assign dj2 = {PosW'(0), dj} * {PosW'(0), dj};

  always_ff @(posedge clk_i) begin
    a_d2   <= {1'b0, di2} + {1'b0, dj2};
    a_addr <= waddr_q;
    a_last <= issue_last;
  end

  // Stage B: h^2 * d2, clamped where the kernel is already zero
  logic [HsqW+D2W-1:0] prod_full;
  logic [ProdW-1:0]    b_prod;
  logic                b_v, b_last;
  logic [AddrW-1:0]    b_addr;

  assign prod_full = {D2W'(0), hsq_q} * {HsqW'(0), a_d2};

  always_ff @(posedge clk_i) begin
    b_prod <= (prod_full > ProdLimit) ? ProdLimit[ProdW-1:0] : prod_full[ProdW-1:0];
    b_addr <= a_addr;
    b_last <= a_last;
  end

  // Stage C: t = 1 + h^2 d2, rounded half up to Q.16
  logic [ProdW:0]    t_full;
  logic [T16W-1:0]   c_t16;
  logic              c_v, c_last;
  logic [AddrW-1:0]  c_addr;

  assign t_full = {1'b0, b_prod} + ((ProdW+1)'(1) << 32) + (ProdW+1)'(32768);

  always_ff @(posedge clk_i) begin
    c_t16  <= t_full[41:16];
    c_addr <= b_addr;
    c_last <= b_last;
  end

  // Stage D: t^2
  logic [SqW-1:0]   d_sq;
  logic             d_v, d_last;
  logic [AddrW-1:0] d_addr;

  always_ff @(posedge clk_i) begin
    d_sq   <= {T16W'(0), c_t16} * {T16W'(0), c_t16};
    d_addr <= c_addr;
    d_last <= c_last;
  end

  // Divider: k = (2^49 + t^2) / (2 t^2), one quotient bit per stage
  logic [RemW-1:0]  dv_rem  [DivSteps+1];
  logic [RemW-1:0]  dv_den  [DivSteps+1];
  logic [KW-1:0]    dv_q    [DivSteps+1];
  logic [AddrW-1:0] dv_addr [DivSteps+1];
  logic             dv_last [DivSteps+1];
  logic             dv_v    [DivSteps+1];

  always_ff @(posedge clk_i) begin
    dv_rem[0]  <= (RemW'(1) << 49) + {1'b0, d_sq};
    dv_den[0]  <= {d_sq, 1'b0};
    dv_q[0]    <= '0;
    dv_addr[0] <= d_addr;
    dv_last[0] <= d_last;
  end

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    localparam int B = DivSteps - 1 - s;
    logic [RemW+KW-1:0] shd;
    logic               ge;
    assign shd = {KW'(0), dv_den[s]} << B;
    assign ge  = ({KW'(0), dv_rem[s]} >= shd);
    always_ff @(posedge clk_i) begin
      dv_rem[s+1]  <= ge ? dv_rem[s] - shd[RemW-1:0] : dv_rem[s];
      dv_den[s+1]  <= dv_den[s];
      dv_q[s+1]    <= dv_q[s] | (KW'(ge) << B);
      dv_addr[s+1] <= dv_addr[s];
      dv_last[s+1] <= dv_last[s];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v[s+1] <= 1'b0;
      end else begin
        dv_v[s+1] <= dv_v[s];
      end
    end
  end

  // Valid bits through the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v     <= 1'b0;
      b_v     <= 1'b0;
      c_v     <= 1'b0;
      d_v     <= 1'b0;
      dv_v[0] <= 1'b0;
    end else begin
      a_v     <= issue;
      b_v     <= a_v;
      c_v     <= b_v;
      d_v     <= c_v;
      dv_v[0] <= d_v;
    end
  end

  // Sample store: written by load requests, read in step with the kernel
  logic [SampleW-1:0] rd_data;

  gkc_ram #(
    .Width (SampleW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_req),
    .waddr_i (load_addr_q),
    .wdata_i (sample_i),
    .raddr_i (dv_addr[DivSteps]),
    .rdata_o (rd_data)
  );

  // Stage G: kernel aligned with RAM data
  logic [KW-1:0] g_k;
  logic          g_v, g_last;

  always_ff @(posedge clk_i) begin
    g_k    <= dv_q[DivSteps];
    g_last <= dv_last[DivSteps];
  end

  // Stage H: term = floor(v * k / 2^16)
  logic signed [SampleW+KW:0] mac_prod;
  logic signed [TermW-1:0]    h_term;

  assign mac_prod = $signed(rd_data) * $signed({1'b0, g_k});

  always_ff @(posedge clk_i) begin
    h_term <= TermW'(mac_prod >>> 16);
    h_last <= g_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v <= 1'b0;
      h_v <= 1'b0;
    end else begin
      g_v <= dv_v[DivSteps];
      h_v <= g_v;
    end
  end

  // Accumulator; total stays within 2^42, so the 48-bit range never clips
  logic signed [PotW-1:0] acc_q, acc_d;
  logic                   valid_q, last_q;
  logic signed [PotW-1:0] pot_q;

  assign acc_d = acc_q + PotW'(h_term);

  always_ff @(posedge clk_i) begin
    if (read_req) begin
      acc_q <= '0;
    end else if (h_v) begin
      acc_q <= acc_d;
    end
    if (h_v && h_last) begin
      pot_q  <= acc_d;
      last_q <= (rd_col_q == col_max) && (rd_row_q == row_max);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= h_v && h_last && (state_q == StDrain);
    end
  end

  assign valid_o      = valid_q;
  assign potential_o  = pot_q;
  assign last_point_o = last_q;

endmodule

// ===== sv/gkc_chk.sv =====
// gkc_chk: port-level checks on the request/result timing of the grid kernel
// convolution block, bound onto the top level. Depends on the top level only.
module gkc_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic action_i,
  input logic valid_o
);

  // a read ends with its result; the strobe is seen with busy released
  a_fell_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o) else $error("busy dropped without a result");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result strobe while busy");

  // only a read request makes the block busy
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && action_i)) else $error("busy without read request");

  // a load request never makes the block busy
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !action_i) |=> !busy) else $error("load request held busy");

  a_one_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

endmodule

bind grid_kernel_convolution_2d gkc_chk u_gkc_chk (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for grid_kernel_convolution_2d: a directed table, then random
// grids, each read checked against the table or a direct 2D convolution predictor.
// Depends on gkc_pkg and the block's RTL.
module testbench;
  import gkc_pkg::*;

  localparam logic ActLoad = 1'b0;
  localparam logic ActRead = 1'b1;
  localparam int   StallLimit = 6000;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    logic        act;
    logic [31:0] smp;
    bit          typed;
    logic [47:0] pot;
    logic        last;
  } row_t;

  typedef struct {
    logic [47:0] pot;
    logic        last;
  } point_t;

  logic        clk_i, rst_ni;
  logic        start, busy, action_i;
  logic [31:0] sample_i;
  logic        valid_o, last_point_o;
  logic [47:0] potential_o;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  grid_kernel_convolution_2d i_dut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .sample_i,
    .valid_o, .potential_o, .last_point_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predictor state
  logic [31:0] grid_mem [StoreDepth];
  bit          grid_written [StoreDepth];
  int          load_pos, read_pos;
  logic [5:0]  cols_reg, rows_reg;
  logic [23:0] h_reg;

  point_t potential_q[$];
  row_t   table_q[$];
  int     errors, items, idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int side_clamp(logic [5:0] v);
    if (v == 0) return 1;
    if (v > MaxSide) return MaxSide;
    return int'(v);
  endfunction

  // kernel 1/t^2 rounded to Q1.16
  function automatic logic [63:0] kernel_weight(logic [23:0] h, int d2);
    logic [63:0] hsq, lim, prod, t16, sq;
    hsq = {40'd0, h} * {40'd0, h};
    lim = 64'd1 << 41;
    if (hsq != 0 && 64'(d2) > lim / hsq) prod = lim;
    else prod = hsq * 64'(d2);
    if (prod > lim) prod = lim;
    t16 = ((64'd1 << 32) + prod + 64'd32768) >> 16;
    sq  = t16 * t16;
    return ((64'd1 << 49) + sq) / (2 * sq);
  endfunction

  function automatic logic [47:0] grid_potential(int pos);
    int     nc, nr, ci, cj, di, dj;
    longint acc, v;
    nc = side_clamp(cols_reg);
    nr = side_clamp(rows_reg);
    ci = pos % nc;
    cj = pos / nc;
    acc = 0;
    for (int r = 0; r < nr; r++) begin
      dj = r - cj;
      for (int c = 0; c < nc; c++) begin
        di = c - ci;
        v = longint'(signed'(grid_mem[r * nc + c]));
        acc += (v * longint'(kernel_weight(h_reg, di * di + dj * dj))) >>> 16;
      end
    end
    if (acc > 64'sh7FFF_FFFF_FFFF) acc = 64'sh7FFF_FFFF_FFFF;
    if (acc < -64'sh8000_0000_0000) acc = -64'sh8000_0000_0000;
    return acc[47:0];
  endfunction

  function automatic bit grid_loaded();
    int n;
    n = side_clamp(cols_reg) * side_clamp(rows_reg);
    for (int i = 0; i < n; i++) if (!grid_written[i]) return 0;
    return 1;
  endfunction

  // advance predictor on an accepted request
  function automatic void grid_step(logic act, logic [31:0] smp, bit typed,
                                    logic [47:0] pot, logic last);
    int     n;
    point_t p;
    n = side_clamp(cols_reg) * side_clamp(rows_reg);
    if (load_pos >= n) load_pos = 0;
    if (read_pos >= n) read_pos = 0;
    if (act == ActLoad) begin
      grid_mem[load_pos] = smp;
      grid_written[load_pos] = 1;
      load_pos = (load_pos + 1 >= n) ? 0 : load_pos + 1;
    end else begin
      p.pot  = typed ? pot : grid_potential(read_pos);
      p.last = typed ? last : (read_pos + 1 == n);
      potential_q.push_back(p);
      read_pos = (read_pos + 1 >= n) ? 0 : read_pos + 1;
    end
  endfunction

  function automatic void add_row(bit is_cfg, logic [1:0] idx, logic [31:0] value,
                                  logic act, logic [31:0] smp, bit typed,
                                  logic [47:0] pot, logic last);
    row_t r;
    r = '{is_cfg, idx, value, act, smp, typed, pot, last};
    table_q.push_back(r);
  endfunction

  // wait for idle, then one APB write
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    while (potential_q.size() != 0 || busy) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    idle_cycles = 0;
    if (idx == RegCols) begin
      cols_reg = value[5:0]; load_pos = 0; read_pos = 0;
    end else if (idx == RegRows) begin
      rows_reg = value[5:0]; load_pos = 0; read_pos = 0;
    end else if (idx == RegSpacing) begin
      h_reg = value[23:0];
    end
  endtask

  // one request, with an optional idle burst first
  task automatic send(logic act, logic [31:0] smp, bit typed, logic [47:0] pot,
                      logic last);
    if (items < 500 && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    start <= 1'b1; action_i <= act; sample_i <= smp;
    do @(posedge clk_i); while (busy);
    grid_step(act, smp, typed, pot, last);
    items++;
    idle_cycles = 0;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return $urandom();
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    point_t p;
    if (rst_ni && valid_o) begin
      idle_cycles = 0;
      if (potential_q.size() == 0) begin
        errors++;
        $display("%t: unexpected result potential=%h last=%b",
                 $realtime, potential_o, last_point_o);
      end else begin
        p = potential_q.pop_front();
        if (potential_o !== p.pot) begin
          errors++;
          $display("%t: potential expected %h actual %h", $realtime, p.pot, potential_o);
        end
        if (last_point_o !== p.last) begin
          errors++;
          $display("%t: last_point expected %b actual %b", $realtime, p.last, last_point_o);
        end
      end
    end
  end

  // watchdog on stalled progress
  always @(posedge clk_i) begin
    idle_cycles++;
    if (idle_cycles > StallLimit) begin
      $display("** grid_kernel_convolution_2d: FAILED **");
      $finish;
    end
  end

  initial begin
    int nc_raw, nr_raw, n, m;
    errors = 0; items = 0; idle_cycles = 0;
    load_pos = 0; read_pos = 0;
    cols_reg = 6'd32; rows_reg = 6'd32; h_reg = 24'd65536;
    foreach (grid_written[i]) begin
      grid_written[i] = 0;
      grid_mem[i] = '0;
    end
    rst_ni = 1'b0; start = 1'b0; action_i = 1'b0; sample_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single points at the extremes, flat kernel, clamped sizes
    add_row(1, RegCols, 1, ActLoad, 0, 0, 0, 0);
    add_row(1, RegRows, 1, ActLoad, 0, 0, 0, 0);
    add_row(1, RegSpacing, 65536, ActLoad, 0, 0, 0, 0);
    add_row(0, 0, 0, ActLoad, 32'h7FFF_FFFF, 0, 0, 0);
    add_row(0, 0, 0, ActRead, 0, 1, 48'h0000_7FFF_FFFF, 1);
    add_row(0, 0, 0, ActLoad, 32'h8000_0000, 0, 0, 0);
    add_row(0, 0, 0, ActRead, 0, 1, 48'hFFFF_8000_0000, 1);
    add_row(1, RegSpacing, 0, ActLoad, 0, 0, 0, 0);
    add_row(1, RegCols, 2, ActLoad, 0, 0, 0, 0);
    add_row(0, 0, 0, ActLoad, 32'h0001_0000, 0, 0, 0);
    add_row(0, 0, 0, ActLoad, 32'hFFFF_8000, 0, 0, 0);
    add_row(0, 0, 0, ActRead, 0, 1, 48'h0000_0000_8000, 0);
    add_row(0, 0, 0, ActRead, 0, 1, 48'h0000_0000_8000, 1);
    add_row(1, RegCols, 0, ActLoad, 0, 0, 0, 0);
    add_row(0, 0, 0, ActRead, 0, 1, 48'h0000_0001_0000, 1);
    add_row(1, 2'd3, 32'hFFFF_FFFF, ActLoad, 0, 0, 0, 0);
    add_row(1, RegSpacing, 32'hFFFF_FFFF, ActLoad, 0, 0, 0, 0);
    add_row(1, RegCols, 2, ActLoad, 0, 0, 0, 0);
    add_row(0, 0, 0, ActRead, 0, 0, 0, 0);
    add_row(0, 0, 0, ActRead, 0, 0, 0, 0);
    add_row(0, 0, 0, ActLoad, 32'h0000_0000, 0, 0, 0);
    add_row(0, 0, 0, ActRead, 0, 0, 0, 0);
    foreach (table_q[i]) begin
      if (table_q[i].is_cfg) begin
        start <= 1'b0;
        reg_write(table_q[i].reg_idx, table_q[i].value);
      end else begin
        send(table_q[i].act, table_q[i].smp, table_q[i].typed,
             table_q[i].pot, table_q[i].last);
      end
    end

    // a wide 32x16 grid once, then random small grids
    for (int ph = 0; items < 580 || ph < 2; ph++) begin
      start <= 1'b0;
      if (ph == 0) begin
        nc_raw = 32; nr_raw = 16;
      end else begin
        case ($urandom_range(0, 9))
          0: nc_raw = 0;
          1: nc_raw = 63;
          2: nc_raw = 32;
          3: nc_raw = 1;
          default: nc_raw = $urandom_range(1, 6);
        endcase
        if (side_clamp(6'(nc_raw)) > 6)
          nr_raw = $urandom_range(0, 2);
        else if ($urandom_range(0, 7) == 0)
          nr_raw = ($urandom_range(0, 1) != 0) ? 63 : 32;
        else
          nr_raw = $urandom_range(0, 6);
        if (side_clamp(6'(nr_raw)) > 6 && side_clamp(6'(nc_raw)) > 2) nc_raw = 2;
      end
      case ($urandom_range(0, 4))
        0: reg_write(RegSpacing, 0);
        1: reg_write(RegSpacing, 32'h00FF_FFFF);
        2: reg_write(RegSpacing, 65536);
        default: reg_write(RegSpacing,
                           {8'($urandom_range(0, 255)), 24'(0)} | $urandom_range(0, 1 << 19));
      endcase
      reg_write(RegCols, 32'(nc_raw));
      reg_write(RegRows, 32'(nr_raw));
      n = side_clamp(cols_reg) * side_clamp(rows_reg);
      m = (ph == 0) ? n + 3 : n + $urandom_range(3, 10);
      for (int k = 0; k < m; k++) begin
        if (grid_loaded() && $urandom_range(0, 1) == 1)
          send(ActRead, $urandom(), 0, 0, 0);
        else
          send(ActLoad, rand_sample(), 0, 0, 0);
      end
    end
    start <= 1'b0;

    while (potential_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("** grid_kernel_convolution_2d: PASSED **");
    end else begin
      $display("** grid_kernel_convolution_2d: FAILED **");
    end
    $finish;
  end

endmodule
